// ----- design/mfba_pkg.sv -----
// mfba_pkg: shared types and constants for the max flow engine
// item structs, opcode and status codes, register indexes, controller states
// no dependencies; imported by mfba_ram users and the top level
`default_nettype none

package mfba_pkg;

   // default sizes of the graph stores
   localparam int unsigned MAX_VERTICES_DEF = 256;
   localparam int unsigned MAX_EDGES_DEF    = 1024;

   // fixed field widths
   localparam int unsigned VERTEX_W = 8;
   localparam int unsigned CAP_W    = 31;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned VCOUNT_W = 9;

   // largest flow value, also the saturation point of a run total
   localparam logic [CAP_W-1:0] FLOW_MAX = 31'h7FFF_FFFF;

   // register reset values
   localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RST = 9'd2;
   localparam logic [VERTEX_W-1:0] SOURCE_RST      = 8'd0;
   localparam logic [VERTEX_W-1:0] SINK_RST        = 8'd1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_RUN   = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_NOT_LOADED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_VERTEX_COUNT = 2'd0,
      REG_SOURCE       = 2'd1,
      REG_SINK         = 2'd2
   } reg_index_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [VERTEX_W-1:0]  from_vertex;
      logic [VERTEX_W-1:0]  to_vertex;
      logic [CAP_W-1:0]     capacity;
      logic [INDEX_W-1:0]   edge_index;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      status_type                status;
   } rsp_item_type;

   // static part of one directed edge
   typedef struct packed {
      logic [VERTEX_W-1:0] tail;
      logic [VERTEX_W-1:0] head;
      logic [CAP_W-1:0]    capacity;
   } edge_entry_type;

   typedef enum logic [4:0] {
      S_SWEEP,
      S_IDLE,
      S_DONE,
      S_READ,
      S_ADD_W0,
      S_ADD_W1,
      S_LNK_RD,
      S_LNK_UPD,
      S_LNK_NEXT,
      S_BFS_CLR,
      S_BFS_INIT,
      S_BFS_POP,
      S_BFS_U,
      S_BFS_U2,
      S_BFS_E,
      S_BFS_E2,
      S_BFS_E3,
      S_AUG_P,
      S_AUG_P2,
      S_AUG_F,
      S_AUG_R
   } state_type;

endpackage

`default_nettype wire

// ----- design/max_flow_bfs_augment.sv -----
// Edmonds-Karp maximum flow engine. One item at a time: a clear runs the adjacency sweep,
// which also runs once after reset, with the input stalled. Per search, a run clears the
// reached marks and seeds the source, dequeues vertices and scans their edges, and then
// pushes flow along each edge of the augmenting path and closes it; every step is one
// access to the single-port-pair memories that hold the graph.
// Results wait in an output register.
// depends on mfba_pkg and mfba_ram
`default_nettype none

module max_flow_bfs_augment #(
   parameter int unsigned MAX_VERTICES = mfba_pkg::MAX_VERTICES_DEF,
   parameter int unsigned MAX_EDGES    = mfba_pkg::MAX_EDGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mfba_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mfba_pkg::rsp_item_type rsp_item,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   import mfba_pkg::*;

   localparam int unsigned VAW  = $clog2(MAX_VERTICES);
   localparam int unsigned EAW  = $clog2(MAX_EDGES);
   localparam int unsigned EW1  = $clog2(MAX_EDGES + 1);
   localparam int unsigned QW   = $clog2(MAX_VERTICES + 1);
   localparam int unsigned NW0  = $clog2(MAX_VERTICES + 1);
   localparam int unsigned NW   = (NW0 > VCOUNT_W) ? NW0 : VCOUNT_W;
   localparam int unsigned IW   = (EW1 > INDEX_W) ? EW1 : INDEX_W;
   localparam logic [EW1-1:0] END_MARK = EW1'(MAX_EDGES);

   typedef struct packed {
      logic [EW1-1:0] head;
      logic [EW1-1:0] tail;
   } adj_entry_type;

   typedef struct packed {
      logic             reached;
      logic [EAW-1:0]   parent;
      logic [CAP_W-1:0] bottleneck;
   } vtx_entry_type;

   // configuration registers
   logic [VCOUNT_W-1:0] vertex_count_ff;
   logic [VERTEX_W-1:0] source_ff;
   logic [VERTEX_W-1:0] sink_ff;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RST;
         source_ff       <= SOURCE_RST;
         sink_ff         <= SINK_RST;
      end else if (csr_write) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_VERTEX_COUNT: vertex_count_ff <= csr_pwdata[VCOUNT_W-1:0];
            REG_SOURCE:       source_ff       <= csr_pwdata[VERTEX_W-1:0];
            REG_SINK:         sink_ff         <= csr_pwdata[VERTEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_VERTEX_COUNT: csr_prdata = 32'(vertex_count_ff);
         REG_SOURCE:       csr_prdata = 32'(source_ff);
         REG_SINK:         csr_prdata = 32'(sink_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end

   // effective vertex count
   logic [NW-1:0] n_w;
   assign n_w = (NW'(vertex_count_ff) < NW'(MAX_VERTICES)) ? NW'(vertex_count_ff)
                                                           : NW'(MAX_VERTICES);

   // memory ports
   logic                 edge_wr_en;
   logic [EAW-1:0]       edge_wr_addr, edge_rd_addr;
   edge_entry_type       edge_wr_data, edge_rd_data;
   logic                 flow_wr_en;
   logic [EAW-1:0]       flow_wr_addr, flow_rd_addr;
   logic [VALUE_W-1:0]   flow_wr_data, flow_rd_data;
   logic                 next_wr_en;
   logic [EAW-1:0]       next_wr_addr, next_rd_addr;
   logic [EW1-1:0]       next_wr_data, next_rd_data;
   logic                 adj_wr_en;
   logic [VAW-1:0]       adj_wr_addr, adj_rd_addr;
   adj_entry_type        adj_wr_data, adj_rd_data;
   logic                 vtx_wr_en;
   logic [VAW-1:0]       vtx_wr_addr, vtx_rd_addr;
   vtx_entry_type        vtx_wr_data, vtx_rd_data;
   logic                 q_wr_en;
   logic [VAW-1:0]       q_wr_addr, q_rd_addr;
   logic [VAW-1:0]       q_wr_data, q_rd_data;

   mfba_ram #(.WIDTH($bits(edge_entry_type)), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(edge_wr_en), .wr_addr(edge_wr_addr), .wr_data(edge_wr_data),
      .rd_addr(edge_rd_addr), .rd_data(edge_rd_data));

   mfba_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_EDGES)) u_flow_ram (
      .clock(clock), .wr_en(flow_wr_en), .wr_addr(flow_wr_addr), .wr_data(flow_wr_data),
      .rd_addr(flow_rd_addr), .rd_data(flow_rd_data));

   mfba_ram #(.WIDTH(EW1), .DEPTH(MAX_EDGES)) u_next_ram (
      .clock(clock), .wr_en(next_wr_en), .wr_addr(next_wr_addr), .wr_data(next_wr_data),
      .rd_addr(next_rd_addr), .rd_data(next_rd_data));

   mfba_ram #(.WIDTH($bits(adj_entry_type)), .DEPTH(MAX_VERTICES)) u_adj_ram (
      .clock(clock), .wr_en(adj_wr_en), .wr_addr(adj_wr_addr), .wr_data(adj_wr_data),
      .rd_addr(adj_rd_addr), .rd_data(adj_rd_data));

   mfba_ram #(.WIDTH($bits(vtx_entry_type)), .DEPTH(MAX_VERTICES)) u_vtx_ram (
      .clock(clock), .wr_en(vtx_wr_en), .wr_addr(vtx_wr_addr), .wr_data(vtx_wr_data),
      .rd_addr(vtx_rd_addr), .rd_data(vtx_rd_data));

   mfba_ram #(.WIDTH(VAW), .DEPTH(MAX_VERTICES)) u_queue_ram (
      .clock(clock), .wr_en(q_wr_en), .wr_addr(q_wr_addr), .wr_data(q_wr_data),
      .rd_addr(q_rd_addr), .rd_data(q_rd_data));

   // controller registers
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;
   logic                  sweep_reply_ff, sweep_reply_in;
   req_item_type          cur_ff, cur_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   status_type            res_status_ff, res_status_in;
   logic [EW1-1:0]        loaded_ff, loaded_in;
   logic [VAW-1:0]        cnt_ff, cnt_in;
   logic [EAW-1:0]        add_e_ff, add_e_in;
   logic [VERTEX_W-1:0]   lv_ff, lv_in;
   logic [EAW-1:0]        le_ff, le_in;
   logic                  second_ff, second_in;
   logic [EW1-1:0]        old_tail_ff, old_tail_in;
   logic [CAP_W-1:0]      total_ff, total_in;
   logic [QW-1:0]         qh_ff, qh_in, qt_ff, qt_in;
   logic [EW1-1:0]        e_ff, e_in;
   logic [CAP_W-1:0]      bu_ff, bu_in;
   logic [VERTEX_W-1:0]   h_ff, h_in;
   logic [CAP_W-1:0]      room_ff, room_in;
   logic                  has_room_ff, has_room_in;
   logic [EW1-1:0]        nxt_ff, nxt_in;
   logic [CAP_W-1:0]      push_ff, push_in;
   logic [VERTEX_W-1:0]   v_ff, v_in;
   logic [QW-1:0]         steps_ff, steps_in;
   logic [EAW-1:0]        aug_e_ff, aug_e_in;

   logic                  req_accept;
   logic [CAP_W+1:0]      room_w;
   logic [CAP_W-1:0]      bn_w;
   logic [VALUE_W-1:0]    sum_w;
   adj_entry_type         adj_upd_w;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   // residual room of the scanned edge, bottleneck through it, run total
   assign room_w    = (CAP_W+2)'(edge_rd_data.capacity)
                      - {flow_rd_data[VALUE_W-1], flow_rd_data};
   assign bn_w      = (room_ff < bu_ff) ? room_ff : bu_ff;
   assign sum_w     = VALUE_W'(total_ff) + VALUE_W'(push_ff);

   // list append for the vertex being linked
   always_comb begin
      adj_upd_w.head = (adj_rd_data.tail == END_MARK) ? EW1'(le_ff) : adj_rd_data.head;
      adj_upd_w.tail = EW1'(le_ff);
   end

   // state and data registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_SWEEP;
         rsp_valid_ff   <= 1'b0;
         sweep_reply_ff <= 1'b0;
         loaded_ff      <= '0;
         cnt_ff         <= '0;
         qh_ff          <= '0;
         qt_ff          <= '0;
         steps_ff       <= '0;
         second_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         sweep_reply_ff <= sweep_reply_in;
         loaded_ff      <= loaded_in;
         cnt_ff         <= cnt_in;
         qh_ff          <= qh_in;
         qt_ff          <= qt_in;
         steps_ff       <= steps_in;
         second_ff      <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff   <= rsp_item_in;
      cur_ff        <= cur_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      add_e_ff      <= add_e_in;
      lv_ff         <= lv_in;
      le_ff         <= le_in;
      old_tail_ff   <= old_tail_in;
      total_ff      <= total_in;
      e_ff          <= e_in;
      bu_ff         <= bu_in;
      h_ff          <= h_in;
      room_ff       <= room_in;
      has_room_ff   <= has_room_in;
      nxt_ff        <= nxt_in;
      push_ff       <= push_in;
      v_ff          <= v_in;
      aug_e_ff      <= aug_e_in;
   end

   // next state, memory accesses
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_item_in    = rsp_item_ff;
      sweep_reply_in = sweep_reply_ff;
      cur_in         = cur_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      loaded_in      = loaded_ff;
      cnt_in         = cnt_ff;
      add_e_in       = add_e_ff;
      lv_in          = lv_ff;
      le_in          = le_ff;
      second_in      = second_ff;
      old_tail_in    = old_tail_ff;
      total_in       = total_ff;
      qh_in          = qh_ff;
      qt_in          = qt_ff;
      e_in           = e_ff;
      bu_in          = bu_ff;
      h_in           = h_ff;
      room_in        = room_ff;
      has_room_in    = has_room_ff;
      nxt_in         = nxt_ff;
      push_in        = push_ff;
      v_in           = v_ff;
      steps_in       = steps_ff;
      aug_e_in       = aug_e_ff;

      edge_wr_en   = 1'b0;
      edge_wr_addr = add_e_ff;
      edge_wr_data = '{tail: cur_ff.from_vertex, head: cur_ff.to_vertex,
                       capacity: cur_ff.capacity};
      edge_rd_addr = e_ff[EAW-1:0];
      flow_wr_en   = 1'b0;
      flow_wr_addr = add_e_ff;
      flow_wr_data = '0;
      flow_rd_addr = e_ff[EAW-1:0];
      next_wr_en   = 1'b0;
      next_wr_addr = add_e_ff;
      next_wr_data = END_MARK;
      next_rd_addr = e_ff[EAW-1:0];
      adj_wr_en    = 1'b0;
      adj_wr_addr  = cnt_ff;
      adj_wr_data  = '{head: END_MARK, tail: END_MARK};
      adj_rd_addr  = VAW'(lv_ff);
      vtx_wr_en    = 1'b0;
      vtx_wr_addr  = cnt_ff;
      vtx_wr_data  = '{reached: 1'b0, parent: '0, bottleneck: '0};
      vtx_rd_addr  = VAW'(v_ff);
      q_wr_en      = 1'b0;
      q_wr_addr    = qt_ff[VAW-1:0];
      q_wr_data    = VAW'(source_ff);
      q_rd_addr    = qh_ff[VAW-1:0];

      case (state_ff)
         // empty every adjacency list, one vertex a cycle
         S_SWEEP: begin
            adj_wr_en = 1'b1;
            if (cnt_ff == VAW'(MAX_VERTICES - 1)) begin
               cnt_in   = '0;
               state_in = sweep_reply_ff ? S_DONE : S_IDLE;
            end else begin
               cnt_in = cnt_ff + VAW'(1);
            end
         end

         // decode a new item
         S_IDLE: begin
            if (req_accept) begin
               cur_in        = req_item;
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               case (req_item.opcode)
                  OP_CLEAR: begin
                     loaded_in      = '0;
                     cnt_in         = '0;
                     sweep_reply_in = 1'b1;
                     state_in       = S_SWEEP;
                  end
                  OP_ADD: begin
                     if (32'(loaded_ff) + 32'd2 > 32'(MAX_EDGES)) begin
                        res_status_in = STATUS_FULL;
                        state_in      = S_DONE;
                     end else begin
                        add_e_in  = loaded_ff[EAW-1:0];
                        loaded_in = loaded_ff + EW1'(2);
                        state_in  = S_ADD_W0;
                     end
                  end
                  OP_RUN: begin
                     total_in = '0;
                     cnt_in   = '0;
                     if (NW'(source_ff) >= n_w || NW'(sink_ff) >= n_w
                         || source_ff == sink_ff) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_BFS_CLR;
                     end
                  end
                  OP_READ: begin
                     flow_rd_addr = EAW'(req_item.edge_index);
                     if (IW'(req_item.edge_index) < IW'(loaded_ff)) begin
                        state_in = S_READ;
                     end else begin
                        res_status_in = STATUS_NOT_LOADED;
                        state_in      = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_READ: begin
            res_value_in = flow_rd_data;
            state_in     = S_DONE;
         end

         // hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_item_in    = '{result_value: res_value_ff, status: res_status_ff};
               sweep_reply_in = 1'b0;
               state_in       = S_IDLE;
            end
         end

         // forward edge, then its reverse pair
         S_ADD_W0: begin
            edge_wr_en = 1'b1;
            flow_wr_en = 1'b1;
            next_wr_en = 1'b1;
            state_in   = S_ADD_W1;
         end

         S_ADD_W1: begin
            edge_wr_en   = 1'b1;
            edge_wr_addr = add_e_ff + EAW'(1);
            edge_wr_data = '{tail: cur_ff.to_vertex, head: cur_ff.from_vertex,
                             capacity: '0};
            flow_wr_en   = 1'b1;
            flow_wr_addr = add_e_ff + EAW'(1);
            next_wr_en   = 1'b1;
            next_wr_addr = add_e_ff + EAW'(1);
            lv_in        = cur_ff.from_vertex;
            le_in        = add_e_ff;
            second_in    = 1'b0;
            state_in     = S_LNK_RD;
         end

         // append edge le to the list of vertex lv
         S_LNK_RD: begin
            if (NW'(lv_ff) < NW'(MAX_VERTICES)) begin
               state_in = S_LNK_UPD;
            end else begin
               old_tail_in = END_MARK;
               state_in    = S_LNK_NEXT;
            end
         end

         S_LNK_UPD: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = VAW'(lv_ff);
            adj_wr_data = adj_upd_w;
            old_tail_in = adj_rd_data.tail;
            state_in    = S_LNK_NEXT;
         end

         S_LNK_NEXT: begin
            next_wr_en   = (old_tail_ff != END_MARK);
            next_wr_addr = old_tail_ff[EAW-1:0];
            next_wr_data = EW1'(le_ff);
            if (!second_ff) begin
               second_in = 1'b1;
               lv_in     = cur_ff.to_vertex;
               le_in     = add_e_ff + EAW'(1);
               state_in  = S_LNK_RD;
            end else begin
               second_in    = 1'b0;
               res_value_in = VALUE_W'(add_e_ff);
               state_in     = S_DONE;
            end
         end

         // clear reached marks before a search
         S_BFS_CLR: begin
            vtx_wr_en = 1'b1;
            if (cnt_ff == VAW'(MAX_VERTICES - 1)) begin
               cnt_in   = '0;
               state_in = S_BFS_INIT;
            end else begin
               cnt_in = cnt_ff + VAW'(1);
            end
         end

         S_BFS_INIT: begin
            vtx_wr_en   = 1'b1;
            vtx_wr_addr = VAW'(source_ff);
            vtx_wr_data = '{reached: 1'b1, parent: '0, bottleneck: FLOW_MAX};
            q_wr_en     = 1'b1;
            q_wr_addr   = '0;
            qh_in       = '0;
            qt_in       = QW'(1);
            state_in    = S_BFS_POP;
         end

         // take the next frontier vertex
         S_BFS_POP: begin
            if (qh_ff < qt_ff) begin
               qh_in    = qh_ff + QW'(1);
               state_in = S_BFS_U;
            end else begin
               res_value_in = VALUE_W'(total_ff);
               qh_in        = '0;
               qt_in        = '0;
               state_in     = S_DONE;
            end
         end

         S_BFS_U: begin
            adj_rd_addr = q_rd_data;
            vtx_rd_addr = q_rd_data;
            state_in    = S_BFS_U2;
         end

         S_BFS_U2: begin
            e_in     = adj_rd_data.head;
            bu_in    = vtx_rd_data.bottleneck;
            state_in = S_BFS_E;
         end

         // walk the adjacency list
         S_BFS_E: begin
            if (e_ff != END_MARK && IW'(e_ff) < IW'(loaded_ff)) begin
               state_in = S_BFS_E2;
            end else begin
               state_in = S_BFS_POP;
            end
         end

         S_BFS_E2: begin
            h_in        = edge_rd_data.head;
            room_in     = room_w[CAP_W-1:0];
            has_room_in = !room_w[CAP_W+1] && (room_w != '0);
            nxt_in      = next_rd_data;
            vtx_rd_addr = VAW'(edge_rd_data.head);
            if (NW'(edge_rd_data.head) < n_w) begin
               state_in = S_BFS_E3;
            end else begin
               e_in     = next_rd_data;
               state_in = S_BFS_E;
            end
         end

         S_BFS_E3: begin
            e_in     = nxt_ff;
            state_in = S_BFS_E;
            if (!vtx_rd_data.reached && has_room_ff) begin
               vtx_wr_en   = 1'b1;
               vtx_wr_addr = VAW'(h_ff);
               vtx_wr_data = '{reached: 1'b1, parent: e_ff[EAW-1:0], bottleneck: bn_w};
               if (h_ff == sink_ff) begin
                  push_in  = bn_w;
                  v_in     = sink_ff;
                  steps_in = '0;
                  qh_in    = '0;
                  qt_in    = '0;
                  state_in = S_AUG_P;
               end else if (qt_ff < QW'(MAX_VERTICES)) begin
                  q_wr_en   = 1'b1;
                  q_wr_data = VAW'(h_ff);
                  qt_in     = qt_ff + QW'(1);
               end
            end
         end

         // push the sink bottleneck back along the parent chain
         S_AUG_P: begin
            if (v_ff == source_ff || steps_ff == QW'(MAX_VERTICES)) begin
               total_in = (sum_w > VALUE_W'(FLOW_MAX)) ? FLOW_MAX : sum_w[CAP_W-1:0];
               cnt_in   = '0;
               state_in = S_BFS_CLR;
            end else begin
               state_in = S_AUG_P2;
            end
         end

         S_AUG_P2: begin
            aug_e_in     = vtx_rd_data.parent;
            flow_rd_addr = vtx_rd_data.parent;
            edge_rd_addr = vtx_rd_data.parent;
            state_in     = S_AUG_F;
         end

         S_AUG_F: begin
            flow_wr_en   = 1'b1;
            flow_wr_addr = aug_e_ff;
            flow_wr_data = flow_rd_data + VALUE_W'(push_ff);
            flow_rd_addr = aug_e_ff ^ EAW'(1);
            v_in         = edge_rd_data.tail;
            state_in     = S_AUG_R;
         end

         S_AUG_R: begin
            flow_wr_en   = 1'b1;
            flow_wr_addr = aug_e_ff ^ EAW'(1);
            flow_wr_data = flow_rd_data - VALUE_W'(push_ff);
            steps_in     = steps_ff + QW'(1);
            state_in     = S_AUG_P;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // checks on the controller
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside the done state");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      qh_ff <= qt_ff)
      else $error("frontier head passed its tail");

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= END_MARK)
      else $error("edge count beyond table size");

   a_aug_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AUG_R) |=> (steps_ff == $past(steps_ff) + QW'(1)))
      else $error("augment step count not advanced");

endmodule

`default_nettype wire

// ----- design/mfba_ram.sv -----
// mfba_ram: generic simple dual port memory, one write and one registered read
// no dependencies
`default_nettype none

module mfba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
